>>> design/rmse_pkg.sv
// Package: widths, transaction types, controller states and sample helpers.
package rmse_pkg;

   localparam int MAX_ITEMS   = 1048576;
   localparam int SAMPLE_BITS = 16;

   localparam int PORT_BITS  = 16;
   localparam int DIFF_BITS  = SAMPLE_BITS + 1;
   localparam int MAG_BITS   = SAMPLE_BITS;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int SUM_BITS   = 52;
   localparam int COUNT_BITS = 21;
   localparam int MSE_BITS   = 32;
   localparam int ROOT_BITS  = MSE_BITS / 2;

   localparam int DIV_STEPS  = SUM_BITS;
   localparam int ROOT_STEPS = ROOT_BITS;
   localparam int ITER_BITS  = $clog2(DIV_STEPS);

   localparam int SQRT_UNIT_BITS = ROOT_BITS + 3;
   localparam int UNIT_BITS = (COUNT_BITS + 1 > SQRT_UNIT_BITS) ?
                              COUNT_BITS + 1 : SQRT_UNIT_BITS;

   typedef struct packed {
      logic signed [PORT_BITS-1:0] observed_sample;
      logic signed [PORT_BITS-1:0] reference_sample;
      logic                        last_item;
   } req_type;

   typedef struct packed {
      logic [MSE_BITS-1:0]   mean_square_error;
      logic [ROOT_BITS-1:0]  root_mean_square_error;
      logic [COUNT_BITS-1:0] pair_count;
      logic                  overflow;
   } rsp_type;

   typedef struct packed {
      logic                 ge;
      logic [UNIT_BITS-1:0] diff;
   } sub_result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_ROOT,
      ST_DONE
   } state_type;

   function automatic logic signed [DIFF_BITS-1:0] sample_value(
      input logic [PORT_BITS-1:0] raw
   );
      logic signed [SAMPLE_BITS-1:0] s;
      s = raw[SAMPLE_BITS-1:0];
      return DIFF_BITS'(s);
   endfunction

   function automatic logic [MAG_BITS-1:0] abs_diff(
      input logic [PORT_BITS-1:0] a,
      input logic [PORT_BITS-1:0] b
   );
      logic signed [DIFF_BITS-1:0] d;
      logic signed [DIFF_BITS-1:0] m;
      d = sample_value(a) - sample_value(b);
      m = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : d;
      return m[MAG_BITS-1:0];
   endfunction

endpackage

>>> design/rmse_sub_unit.sv
// Shared compare-and-subtract unit for the divide and square root steps.
module rmse_sub_unit (
   input  logic [rmse_pkg::UNIT_BITS-1:0] minuend,
   input  logic [rmse_pkg::UNIT_BITS-1:0] subtrahend,
   output rmse_pkg::sub_result_type       result
);
   import rmse_pkg::*;

   logic [UNIT_BITS:0] wide_diff;

   assign wide_diff   = {1'b0, minuend} - {1'b0, subtrahend};
   assign result.ge   = ~wide_diff[UNIT_BITS];
   assign result.diff = wide_diff[UNIT_BITS-1:0];

endmodule

>>> design/rmse_accumulator_core.sv
// Top level: RMSE accumulator with squared-sum, bit-serial divide and root.
//
// Input: present a sample pair on req_item and raise start; the transaction is
// taken at a rising edge where start is high and busy is low. busy stays high
// while the pair is worked on.
// A pair without last_item is taken, then squared in the 16x16 multiplier,
// then added into the 52-bit squared sum. A new pair is taken only once busy
// has dropped again.
// A pair with last_item also runs the shared compare-subtract unit for a
// 52-step restoring divide (sum by count) and then a 16-step digit root; its
// result goes out in ST_DONE, and the next pair can be taken in the cycle after
// the result.
// Result: rsp_valid is high for exactly one cycle with rsp_item; the receiver
// cannot stall, so the result must be taken in that cycle. The sum, count and
// overflow flag clear as the result goes out.
// Pairs past MAX_ITEMS add nothing and set the overflow flag of the set.
// Reset (synchronous, active high) clears the sum, count, flag and controller.
module rmse_accumulator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rmse_pkg::req_type req_item,
   output logic              rsp_valid,
   output rmse_pkg::rsp_type rsp_item
);
   import rmse_pkg::*;

   state_type             state_ff, state_in;
   logic [MAG_BITS-1:0]   mag_ff, mag_in;
   logic                  last_ff, last_in;
   logic [SQ_BITS-1:0]    product_ff, product_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [MSE_BITS-1:0]   mse_ff, mse_in;
   logic [ITER_BITS-1:0]  iter_ff, iter_in;

   logic [UNIT_BITS-1:0]  unit_a;
   logic [UNIT_BITS-1:0]  unit_b;
   sub_result_type        unit_res;
   logic [MSE_BITS-1:0]   quotient;

   rmse_sub_unit u_sub (
      .minuend    (unit_a),
      .subtrahend (unit_b),
      .result     (unit_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      last_ff    <= last_in;
      product_ff <= product_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      mse_ff     <= mse_in;
   end

   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      last_in    = last_ff;
      product_in = product_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      mse_in     = mse_ff;
      iter_in    = iter_ff;
      unit_a     = '0;
      unit_b     = '0;
      quotient   = '0;
      busy       = 1'b1;
      rsp_valid  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               mag_in   = abs_diff(req_item.observed_sample, req_item.reference_sample);
               last_in  = req_item.last_item;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            product_in = SQ_BITS'(mag_ff) * SQ_BITS'(mag_ff);
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (count_ff < COUNT_BITS'(MAX_ITEMS)) begin
               sum_in   = sum_ff + SUM_BITS'(product_ff);
               count_in = count_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            rem_in  = '0;
            iter_in = '0;
            state_in = last_ff ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            unit_a = UNIT_BITS'({rem_ff, sum_ff[SUM_BITS-1]});
            unit_b = UNIT_BITS'(count_ff);
            rem_in = unit_res.ge ? unit_res.diff[COUNT_BITS-1:0] :
                                   unit_a[COUNT_BITS-1:0];
            sum_in = {sum_ff[SUM_BITS-2:0], unit_res.ge};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_BITS'(DIV_STEPS - 1)) begin
               quotient = (count_ff == '0) ? '0 : sum_in[MSE_BITS-1:0];
               mse_in   = quotient;
               sum_in   = SUM_BITS'(quotient);
               rem_in   = '0;
               root_in  = '0;
               iter_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            unit_a  = UNIT_BITS'({rem_ff[COUNT_BITS-3:0], sum_ff[MSE_BITS-1 -: 2]});
            unit_b  = UNIT_BITS'({root_ff, 2'b01});
            rem_in  = unit_res.ge ? unit_res.diff[COUNT_BITS-1:0] :
                                    unit_a[COUNT_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], unit_res.ge};
            sum_in  = {sum_ff[SUM_BITS-3:0], 2'b00};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_BITS'(ROOT_STEPS - 1)) begin
               iter_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            sum_in    = '0;
            count_in  = '0;
            ovf_in    = 1'b0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_item.mean_square_error      = mse_ff;
   assign rsp_item.root_mean_square_error = root_ff;
   assign rsp_item.pair_count             = count_ff;
   assign rsp_item.overflow               = ovf_ff;

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_result_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.pair_count != '0))
      else $error("result with zero pair count");

   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((34'(rsp_item.root_mean_square_error) * 34'(rsp_item.root_mean_square_error))
            <= 34'(rsp_item.mean_square_error)) &&
         ((34'(rsp_item.root_mean_square_error) + 34'd1) *
          (34'(rsp_item.root_mean_square_error) + 34'd1)
            > 34'(rsp_item.mean_square_error)))
      else $error("root is not the floor square root of the mean");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (sum_ff == '0) && (count_ff == '0) && !ovf_ff)
      else $error("accumulator not cleared after result");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_ITEMS))
      else $error("pair count exceeds maximum");

endmodule
